[hdl/tpa_pkg.sv]
// shared types, constants and saturation helpers for the tensor permute address block
// no dependencies

package tpa_pkg;

    localparam int AXES      = 4;
    localparam int MAX_RANK  = 4;
    localparam int SRC_BITS  = 24;
    localparam int DIM_BITS  = 16;
    localparam int TOT_BITS  = 25;
    localparam int MAP_BITS  = 8;
    localparam int RANK_BITS = 3;
    localparam int SAT_BITS  = 41;
    localparam int CFG_BITS  = 3;

    localparam logic [SAT_BITS-1:0] SAT_CAP = {1'b1, {(SAT_BITS-1){1'b0}}};

    localparam logic [CFG_BITS-1:0] CFG_RANK     = 3'd0;
    localparam logic [CFG_BITS-1:0] CFG_DIM_0    = 3'd1;
    localparam logic [CFG_BITS-1:0] CFG_DIM_1    = 3'd2;
    localparam logic [CFG_BITS-1:0] CFG_DIM_2    = 3'd3;
    localparam logic [CFG_BITS-1:0] CFG_DIM_3    = 3'd4;
    localparam logic [CFG_BITS-1:0] CFG_AXIS_MAP = 3'd5;
    localparam logic [CFG_BITS-1:0] CFG_TOTAL    = 3'd6;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_STR,
        ST_IDLE
    } t_seq_state;

    typedef struct packed {
        logic [RANK_BITS-1:0]               rank;
        logic [AXES-1:0][TOT_BITS-1:0]      div;
        logic [AXES-1:0][SAT_BITS-1:0]      stride;
    } t_derived;

    function automatic logic [SAT_BITS-1:0] sat_clip(input logic [64:0] v);
        logic [SAT_BITS-1:0] res;
        if (v > {24'd0, SAT_CAP}) begin
            res = SAT_CAP;
        end else begin
            res = v[SAT_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic [SAT_BITS-1:0] sat_add(input logic [SAT_BITS-1:0] a,
                                                    input logic [SAT_BITS-1:0] b);
        logic [SAT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return sat_clip({23'd0, s});
    endfunction

endpackage

[hdl/tensor_permute_address.sv]
// top level of the tensor permute address generator: registers, setup unit, pipeline
// depends on tpa_pkg, tpa_setup, tpa_pipe

// Maps a row-major source index to its row-major index in the axis-permuted tensor.
// One transaction per cycle is sustained while the output register is free or being taken
// and the setup unit is idle; each index passes the bit-per-stage restoring division
// of each axis followed by its stride multiply before the output register. After reset and
// after every register write the setup unit recomputes the running divisors with a
// serial divider and then the strides, while s_axis_tready is low.
// m_axis_tuser flags a result at or beyond total_size; tdata is then zero.

module tensor_permute_address #(
    parameter int MAX_RANK = tpa_pkg::MAX_RANK
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tpa_pkg::CFG_BITS-1:0]  i_cfg_addr,
    input  logic [tpa_pkg::TOT_BITS-1:0]  i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,   // src_index[23:0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,   // dst_index[23:0]
    output logic [0:0]                    m_axis_tuser    // out_of_range[0]
);
    import tpa_pkg::*;

    logic [RANK_BITS-1:0]          r_rank;
    logic [AXES-1:0][DIM_BITS-1:0] r_dim;
    logic [MAP_BITS-1:0]           r_axis_map;
    logic [TOT_BITS-1:0]           r_total;

    t_derived drv;
    logic     busy;
    logic     advance;
    logic     oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank     <= RANK_BITS'(1);
            r_dim      <= {AXES{DIM_BITS'(1)}};
            r_axis_map <= MAP_BITS'(228);
            r_total    <= TOT_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_RANK:     r_rank     <= i_cfg_data[RANK_BITS-1:0];
                CFG_DIM_0:    r_dim[0]   <= i_cfg_data[DIM_BITS-1:0];
                CFG_DIM_1:    r_dim[1]   <= i_cfg_data[DIM_BITS-1:0];
                CFG_DIM_2:    r_dim[2]   <= i_cfg_data[DIM_BITS-1:0];
                CFG_DIM_3:    r_dim[3]   <= i_cfg_data[DIM_BITS-1:0];
                CFG_AXIS_MAP: r_axis_map <= i_cfg_data[MAP_BITS-1:0];
                CFG_TOTAL:    r_total    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tpa_setup #(.MAX_RANK(MAX_RANK)) u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_rank     (r_rank),
        .i_dim      (r_dim),
        .i_axis_map (r_axis_map),
        .i_total    (r_total),
        .o_drv      (drv),
        .o_busy     (busy)
    );

    // whole pipeline moves together; output register frees it when taken
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance && !busy;

    tpa_pipe #(.MAX_RANK(MAX_RANK)) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_in_valid  (s_axis_tvalid && s_axis_tready),
        .i_src       (s_axis_tdata[SRC_BITS-1:0]),
        .i_drv       (drv),
        .i_total     (r_total),
        .o_out_valid (m_axis_tvalid),
        .o_dst       (m_axis_tdata),
        .o_oor       (oor)
    );

    assign m_axis_tuser = oor;

endmodule

[hdl/tpa_setup.sv]
// setup unit: derives running divisors and destination strides from the registers
// depends on tpa_pkg

module tpa_setup #(
    parameter int MAX_RANK = tpa_pkg::MAX_RANK
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_cfg_we,
    input  logic [tpa_pkg::RANK_BITS-1:0]                   i_rank,
    input  logic [tpa_pkg::AXES-1:0][tpa_pkg::DIM_BITS-1:0] i_dim,
    input  logic [tpa_pkg::MAP_BITS-1:0]                    i_axis_map,
    input  logic [tpa_pkg::TOT_BITS-1:0]                    i_total,
    output tpa_pkg::t_derived                               o_drv,
    output logic                                            o_busy
);
    import tpa_pkg::*;

    t_seq_state r_state, n_state;
    logic c_load, c_step, c_str;

    logic [1:0]                r_axis;
    logic [4:0]                r_cnt;
    logic [TOT_BITS-1:0]       r_dq;
    logic [DIM_BITS-1:0]       r_dr;
    logic [1:0]                r_p;
    logic [SAT_BITS-1:0]       r_acc;
    logic [TOT_BITS-1:0]       r_div    [AXES];
    logic [SAT_BITS-1:0]       r_stride [AXES];

    logic [RANK_BITS-1:0]      rank_cl;
    logic [DIM_BITS-1:0]       size_nz  [AXES];
    logic [1:0]                pos      [AXES];
    logic [DIM_BITS:0]         trial;
    logic                      ge;
    logic [DIM_BITS:0]         diff;
    logic [DIM_BITS-1:0]       sel_size;
    logic [2:0]                k_next;
    logic [DIM_BITS-1:0]       dsel;
    logic [SAT_BITS-1:0]       acc_new;
    logic                      cnt_last;

    always_comb begin
        if (i_rank == '0) begin
            rank_cl = RANK_BITS'(1);
        end else if (int'(i_rank) > MAX_RANK) begin
            rank_cl = RANK_BITS'(MAX_RANK);
        end else begin
            rank_cl = i_rank;
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            size_nz[a] = (i_dim[a] == '0) ? DIM_BITS'(1) : i_dim[a];
            pos[a]     = i_axis_map[2*a +: 2];
        end
    end

    // destination size at position r_p+1: last source axis in use mapped there wins
    assign k_next = {1'b0, r_p} + 3'd1;
    always_comb begin
        dsel = DIM_BITS'(1);
        for (int a = 0; a < AXES; a++) begin
            if (a < int'(rank_cl) && {1'b0, pos[a]} == k_next) begin
                dsel = size_nz[a];
            end
        end
    end

    always_comb begin
        if (k_next < rank_cl) begin
            acc_new = sat_clip({24'd0, r_acc} * {{(65-DIM_BITS){1'b0}}, dsel});
        end else begin
            acc_new = SAT_BITS'(1);
        end
    end

    assign sel_size = size_nz[r_axis];
    assign trial    = {r_dr, r_dq[TOT_BITS-1]};
    assign ge       = trial >= {1'b0, sel_size};
    assign diff     = trial - {1'b0, sel_size};
    assign cnt_last = (r_cnt == 5'(TOT_BITS-1));

    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = ST_LOAD;
        end else begin
            unique case (r_state)
                ST_LOAD: n_state = ST_DIV;
                ST_DIV: begin
                    if (cnt_last && r_axis == 2'(AXES-1)) begin
                        n_state = ST_STR;
                    end else if (cnt_last) begin
                        n_state = ST_LOAD;
                    end
                end
                ST_STR: begin
                    if (r_p == '0) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_IDLE: n_state = ST_IDLE;
                default: n_state = ST_LOAD;
            endcase
        end
    end

    always_comb begin
        c_load = 1'b0;
        c_step = 1'b0;
        c_str  = 1'b0;
        unique case (r_state)
            ST_LOAD: c_load = 1'b1;
            ST_DIV:  c_step = 1'b1;
            ST_STR:  c_str  = 1'b1;
            ST_IDLE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_axis <= '0;
            end else if (c_step && cnt_last) begin
                r_axis <= r_axis + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_dq  <= (r_axis == '0) ? i_total : r_div[r_axis - 2'd1];
            r_dr  <= '0;
            r_cnt <= '0;
            r_acc <= SAT_BITS'(1);
            r_p   <= 2'(AXES-2);
            for (int a = 0; a < AXES; a++) begin
                r_stride[a] <= SAT_BITS'(1);
            end
        end else if (c_step) begin
            r_dr  <= ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
            r_dq  <= {r_dq[TOT_BITS-2:0], ge};
            r_cnt <= r_cnt + 5'd1;
            if (cnt_last) begin
                r_div[r_axis] <= {r_dq[TOT_BITS-2:0], ge};
            end
        end else if (c_str) begin
            r_acc <= acc_new;
            r_p   <= r_p - 2'd1;
            for (int a = 0; a < AXES; a++) begin
                if (pos[a] == r_p) begin
                    r_stride[a] <= acc_new;
                end
            end
        end
    end

    always_comb begin
        o_drv.rank = rank_cl;
        for (int a = 0; a < AXES; a++) begin
            o_drv.div[a]    = r_div[a];
            o_drv.stride[a] = r_stride[a];
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

[hdl/tpa_pipe.sv]
// index pipeline: one quotient bit per stage per axis, then a multiply stage per axis
// depends on tpa_pkg

module tpa_pipe #(
    parameter int MAX_RANK = tpa_pkg::MAX_RANK
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic                          i_in_valid,
    input  logic [tpa_pkg::SRC_BITS-1:0]  i_src,
    input  tpa_pkg::t_derived             i_drv,
    input  logic [tpa_pkg::TOT_BITS-1:0]  i_total,
    output logic                          o_out_valid,
    output logic [tpa_pkg::SRC_BITS-1:0]  o_dst,
    output logic                          o_oor
);
    import tpa_pkg::*;

    localparam int STG = SRC_BITS + 1;
    localparam int NP  = MAX_RANK * STG;
    localparam int CW  = (SRC_BITS + 1 > TOT_BITS) ? SRC_BITS + 1 : TOT_BITS;

    logic [NP-1:0]          r_vld, n_vld;
    logic [SRC_BITS-1:0]    r_rem  [NP];
    logic [SRC_BITS-1:0]    n_rem  [NP];
    logic [SRC_BITS-1:0]    r_part [NP];
    logic [SRC_BITS-1:0]    n_part [NP];
    logic [SRC_BITS-1:0]    r_quo  [NP];
    logic [SRC_BITS-1:0]    n_quo  [NP];
    logic [SAT_BITS-1:0]    r_term [NP];
    logic [SAT_BITS-1:0]    n_term [NP];
    logic [SAT_BITS-1:0]    r_sum  [NP];
    logic [SAT_BITS-1:0]    n_sum  [NP];

    logic                   r_out_vld;
    logic [SRC_BITS-1:0]    r_dst;
    logic                   r_oor;

    for (genvar gs = 0; gs < NP; gs++) begin : g_stage
        localparam int A = gs / STG;
        localparam int J = gs % STG;

        logic                p_vld;
        logic [SRC_BITS-1:0] p_rem, p_part, p_quo;
        logic [SAT_BITS-1:0] p_term, p_sum;

        if (gs == 0) begin : g_first
            assign p_vld  = i_in_valid;
            assign p_rem  = i_src;
            assign p_part = '0;
            assign p_quo  = '0;
            assign p_term = '0;
            assign p_sum  = '0;
        end else begin : g_link
            assign p_vld  = r_vld[gs-1];
            assign p_rem  = r_rem[gs-1];
            assign p_part = r_part[gs-1];
            assign p_quo  = r_quo[gs-1];
            assign p_term = r_term[gs-1];
            assign p_sum  = r_sum[gs-1];
        end

        assign n_vld[gs] = p_vld;

        if (J < SRC_BITS) begin : g_div
            logic [SRC_BITS-1:0] part_in, quo_in;
            logic [SRC_BITS:0]   trial;
            logic [CW-1:0]       t_ext, d_ext, diff;
            logic                ge;

            // first bit of an axis starts a fresh division and folds in the last term
            assign part_in = (J == 0) ? '0 : p_part;
            assign quo_in  = (J == 0) ? '0 : p_quo;
            assign trial   = {part_in, p_rem[SRC_BITS-1-J]};
            assign t_ext   = CW'(trial);
            assign d_ext   = CW'(i_drv.div[A]);
            assign ge      = t_ext >= d_ext;
            assign diff    = t_ext - d_ext;

            assign n_part[gs] = ge ? diff[SRC_BITS-1:0] : trial[SRC_BITS-1:0];
            assign n_quo[gs]  = {quo_in[SRC_BITS-2:0], ge};
            assign n_rem[gs]  = p_rem;
            assign n_sum[gs]  = (J == 0) ? sat_add(p_sum, p_term) : p_sum;
            assign n_term[gs] = (J == 0) ? '0 : p_term;
        end else begin : g_mul
            logic [SRC_BITS-1:0] coord;
            logic [64:0]         prod;

            // zero divisor or unused axis contributes nothing
            assign coord = (i_drv.div[A] == '0 || int'(i_drv.rank) <= A) ? '0 : p_quo;
            assign prod  = {{(65-SRC_BITS){1'b0}}, coord}
                         * {{(65-SAT_BITS){1'b0}}, i_drv.stride[A]};

            assign n_term[gs] = sat_clip(prod);
            assign n_sum[gs]  = p_sum;
            assign n_rem[gs]  = p_part;
            assign n_part[gs] = p_part;
            assign n_quo[gs]  = p_quo;
        end
    end

    logic [SAT_BITS-1:0] tot;
    logic                oor;

    assign tot = sat_add(r_sum[NP-1], r_term[NP-1]);
    assign oor = tot >= {{(SAT_BITS-TOT_BITS){1'b0}}, i_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (i_advance) begin
            r_vld     <= n_vld;
            r_out_vld <= r_vld[NP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int s = 0; s < NP; s++) begin
                r_rem[s]  <= n_rem[s];
                r_part[s] <= n_part[s];
                r_quo[s]  <= n_quo[s];
                r_term[s] <= n_term[s];
                r_sum[s]  <= n_sum[s];
            end
            r_oor <= oor;
            r_dst <= oor ? '0 : tot[SRC_BITS-1:0];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_dst       = r_dst;
    assign o_oor       = r_oor;

endmodule

[hdl/tpa_checker.sv]
// port-level checks for the tensor permute address generator, bound to the top level
// depends on tensor_permute_address

module tpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output changed");

    // out of range result carries a zero index
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
        else $error("out of range result with nonzero index");

    // a register write starts a recompute, input is closed next cycle
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("input open right after register write");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind tensor_permute_address tpa_checker u_tpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[verif/tensor_permute_address_tb.sv]
// testbench for tensor_permute_address: directed and random source indexes over many setups
// depends on tpa_pkg and the tensor_permute_address rtl

module tensor_permute_address_tb;
    import tpa_pkg::*;

    localparam logic [63:0] CAP40 = 64'd1 << 40;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [23:0] dst;
        logic        oor;
    } t_dst_entry;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_addr = '0;
    logic [TOT_BITS-1:0] i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;
    logic [0:0]          m_axis_tuser;

    // shadow copy of the setup registers
    logic [2:0]  reg_rank = 3'd1;
    logic [15:0] reg_dim[4] = '{16'd1, 16'd1, 16'd1, 16'd1};
    logic [7:0]  reg_map = 8'd228;
    logic [24:0] reg_total = 25'd1;

    t_dst_entry dst_queue[$];
    int  mismatches = 0;
    int  sent = 0;
    int  received = 0;
    int  setups = 0;
    int  oor_seen = 0;
    int  cycles = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;

    tensor_permute_address dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, dst_queue.size());
            $display("FAIL tensor_permute_address");
            $finish;
        end
    end

    // receiver backpressure in bursts
    always @(posedge i_clk) begin
        logic rdy;
        rdy = 1'b1;
        if (!quiet) begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                rdy = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 12);
                rdy = 1'b0;
            end
        end
        m_axis_tready <= rdy;
    end

    function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        if (a >= CAP40 || b >= CAP40) p = (a == 0 || b == 0) ? 128'd0 : {64'd0, CAP40};
        else p = a * b;
        return (p > {64'd0, CAP40}) ? CAP40 : p[63:0];
    endfunction

    function automatic t_dst_entry permute_index(logic [23:0] src);
        logic [63:0] sz[4];
        logic [63:0] dsz[4];
        logic [1:0]  pos[4];
        logic [63:0] rem, dv, sum, coord, stride;
        int r;
        t_dst_entry e;
        r = reg_rank;
        if (r == 0) r = 1;
        if (r > MAX_RANK) r = MAX_RANK;
        for (int i = 0; i < 4; i++) begin
            sz[i] = (reg_dim[i] == 0) ? 64'd1 : {48'd0, reg_dim[i]};
            pos[i] = reg_map[2*i +: 2];
            dsz[i] = 64'd1;
        end
        for (int i = 0; i < r; i++) dsz[pos[i]] = sz[i];
        rem = {40'd0, src};
        dv = {39'd0, reg_total};
        sum = 0;
        for (int i = 0; i < r; i++) begin
            dv = dv / sz[i];
            if (dv == 0) begin
                coord = 0;
            end else begin
                coord = rem / dv;
                rem = rem % dv;
            end
            stride = 64'd1;
            for (int k = pos[i] + 1; k < r; k++) stride = mul_sat(stride, dsz[k]);
            sum = sum + mul_sat(coord, stride);
            if (sum > CAP40) sum = CAP40;
        end
        if (sum >= {39'd0, reg_total}) begin
            e.dst = '0;
            e.oor = 1'b1;
        end else begin
            e.dst = sum[23:0];
            e.oor = 1'b0;
        end
        return e;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_dst_entry e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            received++;
            if (dst_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result dst=%h oor=%b", m_axis_tdata, m_axis_tuser);
            end else begin
                e = dst_queue.pop_front();
                if (e.oor) oor_seen++;
                if (m_axis_tdata !== e.dst || m_axis_tuser[0] !== e.oor) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected dst=%h oor=%b, got dst=%h oor=%b",
                                 e.dst, e.oor, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    task automatic send_index(logic [23:0] src);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= src;
        do @(posedge i_clk); while (!s_axis_tready);
        dst_queue.insert(dst_queue.size(), permute_index(src));
        sent++;
    endtask

    // hold the input side until the pipeline has fully drained
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (dst_queue.size() != 0) @(posedge i_clk);
        repeat (110) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_BITS-1:0] addr, logic [TOT_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (addr)
            CFG_RANK:     reg_rank  = data[2:0];
            CFG_DIM_0:    reg_dim[0] = data[15:0];
            CFG_DIM_1:    reg_dim[1] = data[15:0];
            CFG_DIM_2:    reg_dim[2] = data[15:0];
            CFG_DIM_3:    reg_dim[3] = data[15:0];
            CFG_AXIS_MAP: reg_map   = data[7:0];
            CFG_TOTAL:    reg_total = data;
            default: ;
        endcase
    endtask

    task automatic load_setup(int r, int d0, int d1, int d2, int d3, int map, int total);
        drain_all();
        cfg_write(CFG_RANK, TOT_BITS'(r));
        cfg_write(CFG_DIM_0, TOT_BITS'(d0));
        cfg_write(CFG_DIM_1, TOT_BITS'(d1));
        cfg_write(CFG_DIM_2, TOT_BITS'(d2));
        cfg_write(CFG_DIM_3, TOT_BITS'(d3));
        cfg_write(CFG_AXIS_MAP, TOT_BITS'(map));
        cfg_write(CFG_TOTAL, TOT_BITS'(total));
        setups++;
    endtask

    task automatic test_reset_identity();
        send_index(24'd0);
        send_index(24'd1);
        send_index(24'hFFFFFF);
    endtask

    task automatic test_directed();
        // 2x3 transpose, every element
        load_setup(2, 2, 3, 1, 1, 8'b11_10_00_01, 6);
        for (int i = 0; i < 7; i++) send_index(24'(i));
        // widest sizes: strides saturate
        load_setup(4, 65535, 65535, 65535, 65535, 8'b00_01_10_11, 25'd16777216);
        send_index(24'd0);
        send_index(24'hFFFFFF);
        send_index(24'h555555);
        send_index(24'hAAAAAA);
        // rank zero, zero sizes, a register index past the list
        load_setup(0, 0, 5, 0, 0, 8'hFF, 1);
        cfg_write(3'd7, 25'h1FFFFFF);
        send_index(24'd0);
        send_index(24'd3);
        // rank above the maximum, non-permutation map, total smaller than product
        load_setup(7, 3, 4, 5, 2, 8'b01_01_00_00, 50);
        for (int i = 0; i < 6; i++) send_index(24'(i * 11));
        // total larger than product
        load_setup(3, 7, 9, 11, 1, 8'b00_00_01_10, 25'h1FFFFFF);
        send_index(24'd0);
        send_index(24'd123456);
        send_index(24'hFFFFFF);
    endtask

    task automatic test_random_setups(int target);
        int perm[4];
        int d[4];
        int r, t, j, tmp, map, total, n;
        logic [23:0] src;
        while (sent < target) begin
            r = $urandom_range(1, 4);
            for (int i = 0; i < 4; i++) perm[i] = i;
            for (int i = r - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
            end
            if ($urandom_range(0, 5) == 0)
                for (int i = 0; i < 4; i++) perm[i] = $urandom_range(0, 3);
            map = 0;
            total = 1;
            for (int i = 0; i < 4; i++) begin
                map |= perm[i] << (2 * i);
                d[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255)
                                                   : $urandom_range(1, 12);
                if (i < r) total *= d[i];
            end
            if ($urandom_range(0, 7) == 0) total = $urandom_range(1, 2 * total + 5);
            // random high bits on unused axes exercise the write masking
            for (int i = r; i < 4; i++)
                if ($urandom_range(0, 3) == 0) d[i] = $urandom;
            load_setup(r, d[0] & 25'h1FFFFFF, d[1] & 25'h1FFFFFF, d[2] & 25'h1FFFFFF,
                       d[3] & 25'h1FFFFFF, map, total);
            n = $urandom_range(20, 60);
            for (int i = 0; i < n; i++) begin
                t = $urandom_range(0, 15);
                if (t == 0) src = 24'($urandom);
                else if (t == 1) src = 24'(total + $urandom_range(0, 3));
                else src = 24'($urandom_range(0, total - 1));
                send_index(src);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_identity();
        test_directed();
        test_random_setups(1700);
        quiet = 1'b1;
        test_random_setups(2000);
        drain_all();
        $display("covered %0d setups, %0d transactions in, %0d out, %0d flagged out of range",
                 setups, sent, received, oor_seen);
        if (mismatches == 0 && dst_queue.size() == 0) begin
            $display("PASS tensor_permute_address");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, dst_queue.size());
            $display("FAIL tensor_permute_address");
        end
        $finish;
    end

endmodule
